// File: rtl/core/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants for the byte-stream rice encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned KW      = 4;
	localparam logic [KW-1:0] KMin   = 4'd1;
	localparam logic [KW-1:0] KMax   = 4'd8;
	localparam logic [KW-1:0] KReset = 4'd6;

	// input kinds
	localparam logic KindData  = 1'b0;
	localparam logic KindFlush = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} rbe_state_t;

	typedef struct packed {
		logic load;   // latch a new word into the code registers
		logic step;   // produce the next byte or settle the leftover bits
	} rbe_cmd_t;

	typedef struct packed {
		logic fin;       // current step finishes the item
		logic out_free;  // output register can take a byte this cycle
	} rbe_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rbe_ctrl.sv
// ----------------------------------------------------------------------------
// rbe_ctrl
// Sequencer: accepts one word, then steps the datapath until the code is done.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  rbe_pkg::rbe_stat_t     stat,
	output rbe_pkg::rbe_cmd_t      cmd
);
	import rbe_pkg::*;

	rbe_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.out_free && stat.fin) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/rbe_dpath.sv
// ----------------------------------------------------------------------------
// rbe_dpath
// Code registers, bit packer and output register of the rice encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_dpath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [rbe_pkg::KW-1:0] cfg_data,
	input  wire logic                  in_kind,
	input  wire logic [7:0]            in_byte,
	input  rbe_pkg::rbe_cmd_t          cmd,
	output rbe_pkg::rbe_stat_t         stat,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       out_last
);
	import rbe_pkg::*;

	logic [KW-1:0] k_q;
	logic [6:0]    pend_q;
	logic [2:0]    cnt_q;
	logic [6:0]    ones_q;
	logic [15:0]   tail_q;    // remainder bits left-aligned, led by the stop zero
	logic [3:0]    tlen_q;
	logic [7:0]    obyte_q;
	logic          olast_q;
	logic          oval_q;

	logic [KW-1:0] k_eff;
	logic [8:0]    tail_ld;
	logic [4:0]    ones_c;
	logic [15:0]   window;
	logic [15:0]   pend16;
	logic [15:0]   comb;
	logic [7:0]    total;
	logic          emit;
	logic          fin;
	logic [3:0]    n_take;
	logic [3:0]    c_take;
	logic [4:0]    sh_hi;
	logic [3:0]    sh_lo;
	logic [7:0]    left_hi;
	logic [7:0]    left_lo;

	always_comb begin
		if (k_q < KMin) begin
			k_eff = KMin;
		end else if (k_q > KMax) begin
			k_eff = KMax;
		end else begin
			k_eff = k_q;
		end
	end

	// low k bits of the byte, bit k is the zero that ends the unary run
	assign tail_ld = {1'b0, in_byte} & ((9'd1 << k_eff) - 9'd1);

	assign ones_c = (ones_q >= 7'd16) ? 5'd16 : ones_q[4:0];
	// next 16 bits of the remaining code: unary ones, then the tail
	assign window = ~(16'hFFFF >> ones_c) | (tail_q >> ones_c);
	assign pend16 = {9'd0, pend_q} << (5'd16 - {2'd0, cnt_q});
	assign comb   = pend16 | (window >> cnt_q);
	assign total  = {5'd0, cnt_q} + {1'b0, ones_q} + {4'd0, tlen_q};
	assign emit   = total >= 8'd8;
	assign fin    = total < 8'd16;

	assign n_take  = 4'd8 - {1'b0, cnt_q};
	assign c_take  = n_take - ones_q[3:0];
	assign sh_hi   = 5'd16 - total[4:0];
	assign sh_lo   = 4'd8 - total[3:0];
	assign left_hi = comb[7:0] >> sh_hi;
	assign left_lo = comb[15:8] >> sh_lo;

	assign stat.fin      = fin;
	assign stat.out_free = !oval_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= KReset;
			pend_q <= '0;
			cnt_q  <= '0;
			ones_q <= '0;
			tlen_q <= '0;
			oval_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				k_q <= cfg_data;
			end
			if (cmd.step && emit) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
			if (cmd.load) begin
				if (in_kind == KindFlush) begin
					// pad with ones up to the byte boundary
					ones_q <= (cnt_q == 3'd0) ? 7'd0 : {3'd0, 4'd8 - {1'b0, cnt_q}};
					tlen_q <= '0;
				end else begin
					ones_q <= 7'(in_byte >> k_eff);
					tlen_q <= k_eff + 4'd1;
				end
			end else if (cmd.step) begin
				if (fin) begin
					ones_q <= '0;
					tlen_q <= '0;
					if (emit) begin
						pend_q <= left_hi[6:0];
						cnt_q  <= 3'(total - 8'd8);
					end else begin
						pend_q <= left_lo[6:0];
						cnt_q  <= total[2:0];
					end
				end else begin
					cnt_q  <= '0;
					pend_q <= '0;
					if (ones_q >= {3'd0, n_take}) begin
						ones_q <= ones_q - {3'd0, n_take};
					end else begin
						ones_q <= '0;
						tlen_q <= tlen_q - c_take;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tail_q <= (in_kind == KindFlush) ? 16'd0
				: ({7'd0, tail_ld} << (4'd15 - k_eff));
		end else if (cmd.step && !fin && ones_q < {3'd0, n_take}) begin
			tail_q <= tail_q << c_take;
		end
		if (cmd.step && emit) begin
			obyte_q <= comb[15:8];
			olast_q <= fin;
		end
	end

	assign out_valid = oval_q;
	assign out_byte  = obyte_q;
	assign out_last  = olast_q;

endmodule

`default_nettype wire

// File: rtl/core/rice_byte_encoder.sv
// ----------------------------------------------------------------------------
// rice_byte_encoder
// Golomb-Rice coder for a byte stream, code bits packed msb-first into bytes.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                tdata / tuser / tlast
// s_axis    in   s_tvalid / s_tready      tdata: data_byte, tuser: kind
// m_axis    out  m_tvalid / m_tready      tdata: out_byte, tlast: last
// cfg       in   cfg_valid / cfg_ready    cfg_data: rice_k
//
// a word is loaded, then stepped through the packer until its code is done;
// each step emits at most one byte, and a new word is taken only when idle.
// the byte-per-cycle packer sets the rate when not stalled; long unary runs take more steps.
// a full output register with m_tready low holds the packer in place.
// arst_n clears pending bits, the output register and sets rice_k to 6.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_byte_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tuser,   // [0] kind
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast
);
	import rbe_pkg::*;

	rbe_cmd_t  cmd;
	rbe_stat_t stat;

	assign cfg_ready = 1'b1;

	rbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rbe_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire
